// ===== rtl/lwm_pkg.sv =====
// ----------------------------------------------------------------------------
// lwm_pkg
// Shared types and constants of the latency window monitor.
// ----------------------------------------------------------------------------
package lwm_pkg;

    localparam int TIME_W = 64;
    localparam int LIMIT_W = 48;

    // event modes
    localparam logic [2:0] MODE_MASK_OPEN     = 3'd0;
    localparam logic [2:0] MODE_MASK_CLOSE    = 3'd1;
    localparam logic [2:0] MODE_PREEMPT_OPEN  = 3'd2;
    localparam logic [2:0] MODE_PREEMPT_CLOSE = 3'd3;
    localparam logic [2:0] MODE_HANDLER_ENTER = 3'd4;
    localparam logic [2:0] MODE_HANDLER_EXIT  = 3'd5;
    localparam logic [2:0] MODE_READ          = 3'd6;

    // window kinds
    localparam logic [1:0] KIND_MASKED  = 2'd0;
    localparam logic [1:0] KIND_PREEMPT = 2'd1;
    localparam logic [1:0] KIND_HANDLER = 2'd2;

    // read statistics
    localparam logic [2:0] STAT_WORST_NET   = 3'd0;
    localparam logic [2:0] STAT_WORST_GROSS = 3'd1;
    localparam logic [2:0] STAT_WORST_TAG   = 3'd2;
    localparam logic [2:0] STAT_OVER        = 3'd3;
    localparam logic [2:0] STAT_TOTAL       = 3'd4;
    localparam logic [2:0] STAT_STALE       = 3'd5;
    localparam logic [2:0] STAT_IMPL        = 3'd6;
    localparam logic [2:0] STAT_HANDLER     = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_PANIC_MODE   = 3'd1;
    localparam logic [2:0] REG_LIMIT_MASKED = 3'd2;
    localparam logic [2:0] REG_LIMIT_PREEMPT = 3'd3;
    localparam logic [2:0] REG_LIMIT_HANDLER = 3'd4;
    localparam logic [2:0] REG_IMPLAUSIBLE  = 3'd5;
    localparam logic [2:0] REG_REPORT_LIMIT = 3'd6;

    localparam logic [LIMIT_W-1:0] LIMIT_MASKED_RST  = 48'd500000;
    localparam logic [LIMIT_W-1:0] LIMIT_PREEMPT_RST = 48'd2000000;
    localparam logic [LIMIT_W-1:0] LIMIT_HANDLER_RST = 48'd500000;
    localparam logic [7:0]         REPORT_LIMIT_RST  = 8'd8;

    // result item
    typedef struct packed {
        logic              closed;
        logic [1:0]        kind;
        logic [TIME_W-1:0] gross_ticks;
        logic [TIME_W-1:0] net_ticks;
        logic              discarded;
        logic              over_limit;
        logic              panic;
        logic              report;
        logic              budget_spent;
        logic [15:0]       tag;
        logic              stale;
        logic [TIME_W-1:0] read_value;
    } result_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic               enable;
        logic               panic_mode;
        logic [LIMIT_W-1:0] limit_masked;
        logic [LIMIT_W-1:0] limit_preempt;
        logic [LIMIT_W-1:0] limit_handler;
        logic [LIMIT_W-1:0] implausible_ticks;
    } cfg_t;

endpackage

// ===== rtl/lwm_ram.sv =====
// ----------------------------------------------------------------------------
// lwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lwm_cfg.sv =====
// ----------------------------------------------------------------------------
// lwm_cfg
// Configuration register file and the report budget counter.
// ----------------------------------------------------------------------------
module lwm_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_data,
    input  logic           report_take,
    output lwm_pkg::cfg_t  cfg,
    output logic [7:0]     reports_left
);

    logic [7:0] reports_left_reg;

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.enable            <= 1'b0;
            cfg.panic_mode        <= 1'b0;
            cfg.limit_masked      <= lwm_pkg::LIMIT_MASKED_RST;
            cfg.limit_preempt     <= lwm_pkg::LIMIT_PREEMPT_RST;
            cfg.limit_handler     <= lwm_pkg::LIMIT_HANDLER_RST;
            cfg.implausible_ticks <= '0;
            reports_left_reg      <= lwm_pkg::REPORT_LIMIT_RST;
        end
        else
        begin
            if (report_take)
            begin
                reports_left_reg <= reports_left_reg - 8'd1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    lwm_pkg::REG_ENABLE:        cfg.enable <= cfg_data[0];
                    lwm_pkg::REG_PANIC_MODE:    cfg.panic_mode <= cfg_data[0];
                    lwm_pkg::REG_LIMIT_MASKED:  cfg.limit_masked <= cfg_data[47:0];
                    lwm_pkg::REG_LIMIT_PREEMPT: cfg.limit_preempt <= cfg_data[47:0];
                    lwm_pkg::REG_LIMIT_HANDLER: cfg.limit_handler <= cfg_data[47:0];
                    lwm_pkg::REG_IMPLAUSIBLE:   cfg.implausible_ticks <= cfg_data[47:0];
                    lwm_pkg::REG_REPORT_LIMIT:  reports_left_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    assign reports_left = reports_left_reg;

endmodule

// ===== rtl/latency_window_monitor.sv =====
// ----------------------------------------------------------------------------
// latency_window_monitor
// Per-processor monitor of masked, preemption-off and handler windows.
// ----------------------------------------------------------------------------
// Each request passes two states: the first reads the processor's record and
// statistics from block RAM, the second computes the result and writes the
// record back, so no request is accepted while another executes. Results wait
// in an output register; a new request is taken while it waits as long as the
// register frees in time. After reset a clearing pass zeroes every record, one
// processor per cycle, before the first request is taken.
module latency_window_monitor #(
    parameter int CPUS = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [5:0]  cpu,
    input  logic [63:0] now,
    input  logic [15:0] site_id,
    input  logic [7:0]  vector,
    input  logic [1:0]  read_kind,
    input  logic [2:0]  read_stat,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        closed,
    output logic [1:0]  kind,
    output logic [63:0] gross_ticks,
    output logic [63:0] net_ticks,
    output logic        discarded,
    output logic        over_limit,
    output logic        panic,
    output logic        report,
    output logic        budget_spent,
    output logic [15:0] tag,
    output logic        stale,
    output logic [63:0] read_value
);

    localparam int AW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int CW = COUNT_WIDTH;
    // per-cpu record: mask start/site, preempt start/base, handler start/vec/total
    localparam int REC_W = 64 + 16 + 64 + 64 + 64 + 8 + 64;
    // per-kind statistics: worst net, gross, tag, four counters
    localparam int STK_W = 64 + 64 + 16 + 4 * CW;
    localparam int ST_W = 3 * STK_W;
    localparam logic [CW-1:0] CMAX = '1;

    typedef struct packed {
        logic [63:0] mstart;
        logic [15:0] msite;
        logic [63:0] pstart;
        logic [63:0] pbase;
        logic [63:0] hstart;
        logic [7:0]  hvec;
        logic [63:0] htotal;
    } rec_t;

    typedef struct packed {
        logic [63:0]   wnet;
        logic [63:0]   wgross;
        logic [15:0]   wtag;
        logic [CW-1:0] c_over;
        logic [CW-1:0] c_total;
        logic [CW-1:0] c_stale;
        logic [CW-1:0] c_impl;
    } stk_t;

    typedef enum logic [1:0] { S_CLEAR, S_IDLE, S_EXEC } state_t;

    state_t state_reg;
    logic [AW:0] clr_reg;
    logic [2:0]  mode_reg;
    logic [AW-1:0] cpu_reg;
    logic [63:0] now_reg;
    logic [15:0] site_reg;
    logic [7:0]  vec_reg;
    logic [1:0]  rk_reg;
    logic [2:0]  rs_reg;
    logic        ov_reg;
    lwm_pkg::result_t res_reg, res_next;

    lwm_pkg::cfg_t cfg;
    logic [7:0] reports_left;
    logic report_take;

    rec_t rec_rd, rec_wr;
    stk_t [2:0] st_rd, st_wr;
    logic [REC_W-1:0] rec_rdata;
    logic [ST_W-1:0]  st_rdata;
    logic we;
    logic [AW-1:0] waddr, raddr, cpu_in;
    logic accept;

    lwm_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .report_take(report_take),
        .cfg(cfg), .reports_left(reports_left)
    );

    lwm_ram #(.WIDTH(REC_W), .DEPTH(CPUS)) u_rec (
        .clk(clk), .we(we), .waddr(waddr), .wdata(rec_wr),
        .raddr(raddr), .rdata(rec_rdata)
    );

    lwm_ram #(.WIDTH(ST_W), .DEPTH(CPUS)) u_st (
        .clk(clk), .we(we), .waddr(waddr), .wdata(st_wr),
        .raddr(raddr), .rdata(st_rdata)
    );

    assign rec_rd = rec_t'(rec_rdata);
    assign st_rd  = st_rdata;
    assign cfg_ready = 1'b1;

    // cpu beyond range maps to cpu 0
    always_comb
    begin
        if ({3'b0, cpu} >= 9'(CPUS))
        begin
            cpu_in = '0;
        end
        else
        begin
            cpu_in = AW'(cpu);
        end
    end

    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign accept = in_valid && !in_stall;
    assign raddr = cpu_in;

    // execute stage: update record and statistics, form the result
    always_comb
    begin
        logic [1:0] k;
        logic [63:0] gross, net, irq, thr;
        logic do_close;
        stk_t s;
        rec_wr = rec_rd;
        st_wr = st_rd;
        res_next = '0;
        report_take = 1'b0;
        k = lwm_pkg::KIND_MASKED;
        gross = '0;
        net = '0;
        do_close = 1'b0;
        irq = rec_rd.htotal - rec_rd.pbase;
        if (cfg.enable)
        begin
            case (mode_reg)
                lwm_pkg::MODE_MASK_OPEN:
                begin
                    if (rec_rd.mstart != '0)
                    begin
                        res_next.stale = 1'b1;
                        if (st_rd[0].c_stale != CMAX)
                            st_wr[0].c_stale = st_rd[0].c_stale + 1'b1;
                    end
                    rec_wr.msite = site_reg;
                    rec_wr.mstart = now_reg;
                end
                lwm_pkg::MODE_MASK_CLOSE:
                begin
                    if (rec_rd.mstart != '0)
                    begin
                        do_close = 1'b1;
                        k = lwm_pkg::KIND_MASKED;
                        gross = now_reg - rec_rd.mstart;
                        net = gross;
                        res_next.tag = rec_rd.msite;
                        rec_wr.mstart = '0;
                    end
                end
                lwm_pkg::MODE_PREEMPT_OPEN:
                begin
                    if (rec_rd.pstart != '0)
                    begin
                        res_next.stale = 1'b1;
                        if (st_rd[1].c_stale != CMAX)
                            st_wr[1].c_stale = st_rd[1].c_stale + 1'b1;
                    end
                    rec_wr.pbase = rec_rd.htotal;
                    rec_wr.pstart = now_reg;
                end
                lwm_pkg::MODE_PREEMPT_CLOSE:
                begin
                    if (rec_rd.pstart != '0)
                    begin
                        do_close = 1'b1;
                        k = lwm_pkg::KIND_PREEMPT;
                        gross = now_reg - rec_rd.pstart;
                        net = (gross > irq) ? gross - irq : '0;
                        rec_wr.pstart = '0;
                    end
                end
                lwm_pkg::MODE_HANDLER_ENTER:
                begin
                    rec_wr.hvec = vec_reg;
                    rec_wr.hstart = now_reg;
                end
                lwm_pkg::MODE_HANDLER_EXIT:
                begin
                    if (rec_rd.hstart != '0)
                    begin
                        do_close = 1'b1;
                        k = lwm_pkg::KIND_HANDLER;
                        gross = now_reg - rec_rd.hstart;
                        net = gross;
                        res_next.tag = {8'd0, rec_rd.hvec};
                        rec_wr.hstart = '0;
                        rec_wr.htotal = rec_rd.htotal + gross;
                    end
                end
                lwm_pkg::MODE_READ:
                begin
                    if (rs_reg == lwm_pkg::STAT_HANDLER)
                    begin
                        res_next.read_value = rec_rd.htotal;
                    end
                    else if (rk_reg != 2'd3)
                    begin
                        s = st_rd[rk_reg];
                        case (rs_reg)
                            lwm_pkg::STAT_WORST_NET:   res_next.read_value = s.wnet;
                            lwm_pkg::STAT_WORST_GROSS: res_next.read_value = s.wgross;
                            lwm_pkg::STAT_WORST_TAG:   res_next.read_value = 64'(s.wtag);
                            lwm_pkg::STAT_OVER:        res_next.read_value = 64'(s.c_over);
                            lwm_pkg::STAT_TOTAL:       res_next.read_value = 64'(s.c_total);
                            lwm_pkg::STAT_STALE:       res_next.read_value = 64'(s.c_stale);
                            default:                   res_next.read_value = 64'(s.c_impl);
                        endcase
                    end
                end
                default: ;
            endcase
        end
        // common close path
        case (k)
            lwm_pkg::KIND_MASKED:  thr = 64'(cfg.limit_masked);
            lwm_pkg::KIND_PREEMPT: thr = 64'(cfg.limit_preempt);
            default:               thr = 64'(cfg.limit_handler);
        endcase
        s = st_rd[k];
        if (do_close)
        begin
            res_next.closed = 1'b1;
            res_next.kind = k;
            res_next.gross_ticks = gross;
            res_next.net_ticks = net;
            if (s.c_total != CMAX)
                s.c_total = s.c_total + 1'b1;
            if (cfg.implausible_ticks != '0 && net >= 64'(cfg.implausible_ticks))
            begin
                if (s.c_impl != CMAX)
                    s.c_impl = s.c_impl + 1'b1;
                res_next.discarded = 1'b1;
            end
            else
            begin
                if (net > s.wnet)
                begin
                    s.wnet = net;
                    s.wgross = gross;
                    s.wtag = res_next.tag;
                end
                if (net >= thr)
                begin
                    res_next.over_limit = 1'b1;
                    if (s.c_over != CMAX)
                        s.c_over = s.c_over + 1'b1;
                    if (cfg.panic_mode)
                    begin
                        res_next.panic = 1'b1;
                    end
                    else if (reports_left != 8'd0)
                    begin
                        report_take = 1'b1;
                        res_next.report = 1'b1;
                        res_next.budget_spent = (reports_left == 8'd1);
                    end
                end
            end
            st_wr[k] = s;
        end
        if (state_reg == S_CLEAR)
        begin
            rec_wr = '0;
            st_wr = '0;
            report_take = 1'b0;
        end
        else if (state_reg != S_EXEC)
        begin
            report_take = 1'b0;
        end
    end

    assign we = (state_reg == S_CLEAR) || (state_reg == S_EXEC);
    assign waddr = (state_reg == S_CLEAR) ? clr_reg[AW-1:0] : cpu_reg;

    // sequencer, request capture and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(CPUS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            cpu_reg <= cpu_in;
            now_reg <= now;
            site_reg <= site_id;
            vec_reg <= vector;
            rk_reg <= read_kind;
            rs_reg <= read_stat;
        end
        if (state_reg == S_EXEC)
            res_reg <= res_next;
    end

    assign out_valid = ov_reg;
    assign closed = res_reg.closed;
    assign kind = res_reg.kind;
    assign gross_ticks = res_reg.gross_ticks;
    assign net_ticks = res_reg.net_ticks;
    assign discarded = res_reg.discarded;
    assign over_limit = res_reg.over_limit;
    assign panic = res_reg.panic;
    assign report = res_reg.report;
    assign budget_spent = res_reg.budget_spent;
    assign tag = res_reg.tag;
    assign stale = res_reg.stale;
    assign read_value = res_reg.read_value;

endmodule
